### hdl/rcd_pkg.sv
// rcd_pkg: shared constants, codes, types and index helpers for the restricted circular deque
// no dependencies; every other file in hdl/ but rcd_ram refers to it by scoped names

package rcd_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 32;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 3;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [REQ_W-1:0]         req_code_t;
    typedef logic [ST_W-1:0]          status_t;
    typedef logic signed [WORD_W-1:0] word_t;

    localparam req_code_t REQ_INS_R   = 3'd0;
    localparam req_code_t REQ_INS_L   = 3'd1;
    localparam req_code_t REQ_DEL_L   = 3'd2;
    localparam req_code_t REQ_DEL_R   = 3'd3;
    localparam req_code_t REQ_DISPLAY = 3'd4;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_OVERFLOW  = 3'd1;
    localparam status_t ST_UNDERFLOW = 3'd2;
    localparam status_t ST_REJECTED  = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;

    localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
    localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEL,
        S_DISP
    } state_t;

    // what the latched request needs from the controller
    typedef enum logic [1:0] {
        KIND_IMM,
        KIND_DEL,
        KIND_DISP
    } kind_t;

    typedef struct packed {
        logic req_ready;
        logic load_imm;
        logic start_del;
        logic load_del;
        logic start_disp;
        logic disp_step;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  disp_fin;
    } dp_status_t;

    function automatic idx_t next_idx(idx_t i);
        return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
    endfunction

    function automatic idx_t prev_idx(idx_t i);
        return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
    endfunction

endpackage

### hdl/rcd_if.sv
// rcd_if: valid/ready channel interfaces for request, result and mode configuration
// depends on rcd_pkg for field widths

interface rcd_req_if;
    logic                   valid;
    logic                   ready;
    logic [rcd_pkg::REQ_W-1:0]         req_type;
    logic signed [rcd_pkg::WORD_W-1:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface rcd_res_if;
    logic                   valid;
    logic                   ready;
    logic [rcd_pkg::ST_W-1:0]          status;
    logic signed [rcd_pkg::WORD_W-1:0] word_out;
    logic                   last;

    modport source (output valid, status, word_out, last, input ready);
    modport sink   (input valid, status, word_out, last, output ready);
endinterface

interface rcd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/rcd_ram.sv
// rcd_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module rcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rcd_ctrl.sv
// rcd_ctrl: request sequencing state machine of the deque
// depends on rcd_pkg for state, command and status types

module rcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_fire,
    input  rcd_pkg::dp_status_t sts,
    output rcd_pkg::ctrl_cmd_t  cmd
);

    rcd_pkg::state_t state_reg;
    rcd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcd_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = rcd_pkg::S_EXEC;
                end
            end
            rcd_pkg::S_EXEC:
            begin
                unique case (sts.kind)
                    rcd_pkg::KIND_IMM:
                    begin
                        if (sts.out_free)
                        begin
                            state_next = rcd_pkg::S_IDLE;
                        end
                    end
                    rcd_pkg::KIND_DEL:  state_next = rcd_pkg::S_DEL;
                    rcd_pkg::KIND_DISP: state_next = rcd_pkg::S_DISP;
                    default:            state_next = rcd_pkg::S_IDLE;
                endcase
            end
            rcd_pkg::S_DEL:
            begin
                if (sts.out_free)
                begin
                    state_next = rcd_pkg::S_IDLE;
                end
            end
            rcd_pkg::S_DISP:
            begin
                if (sts.out_free && sts.disp_fin)
                begin
                    state_next = rcd_pkg::S_IDLE;
                end
            end
            default: state_next = rcd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            rcd_pkg::S_IDLE:
            begin
                cmd.req_ready = 1'b1;
            end
            rcd_pkg::S_EXEC:
            begin
                unique case (sts.kind)
                    rcd_pkg::KIND_IMM:  cmd.load_imm   = sts.out_free;
                    rcd_pkg::KIND_DEL:  cmd.start_del  = 1'b1;
                    rcd_pkg::KIND_DISP: cmd.start_disp = 1'b1;
                    default:            cmd            = '0;
                endcase
            end
            rcd_pkg::S_DEL:
            begin
                cmd.load_del = sts.out_free;
            end
            rcd_pkg::S_DISP:
            begin
                cmd.disp_step = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

### hdl/rcd_datapath.sv
// rcd_datapath: indices, empty flag, mode register, word store and result register
// depends on rcd_pkg and rcd_ram

module rcd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_fire,
    input  rcd_pkg::req_code_t  req_type,
    input  rcd_pkg::word_t      value,
    input  logic                cfg_fire,
    input  logic                cfg_data,
    input  rcd_pkg::ctrl_cmd_t  cmd,
    output rcd_pkg::dp_status_t sts,
    input  logic                res_ready,
    output logic                res_valid,
    output rcd_pkg::status_t    res_status,
    output rcd_pkg::word_t      res_word,
    output logic                res_last
);

    logic               mode_reg;
    rcd_pkg::idx_t      head_reg, head_next;
    rcd_pkg::idx_t      tail_reg, tail_next;
    logic               empty_reg, empty_next;
    rcd_pkg::req_code_t code_reg;
    rcd_pkg::word_t     value_reg;
    rcd_pkg::idx_t      pos_reg;
    rcd_pkg::idx_t      cnt_reg;
    logic               out_valid_reg, out_valid_next;
    rcd_pkg::status_t   status_reg;
    rcd_pkg::word_t     word_reg;
    logic               last_reg;

    logic               full;
    logic               rejected;
    logic               is_insert;
    logic               is_delete;
    rcd_pkg::status_t   imm_status;
    rcd_pkg::kind_t     kind;
    logic               out_free;
    logic               disp_fin;
    logic               ram_we;
    rcd_pkg::idx_t      ram_waddr;
    logic               ram_re;
    rcd_pkg::idx_t      ram_raddr;
    logic [rcd_pkg::WORD_W-1:0] ram_rdata;

    assign full      = !empty_reg && (rcd_pkg::next_idx(tail_reg) == head_reg);
    assign is_insert = (code_reg == rcd_pkg::REQ_INS_R) || (code_reg == rcd_pkg::REQ_INS_L);
    assign is_delete = (code_reg == rcd_pkg::REQ_DEL_L) || (code_reg == rcd_pkg::REQ_DEL_R);
    // mode check and unknown codes win over full and empty
    assign rejected  = (code_reg > rcd_pkg::REQ_DISPLAY)
        || ((code_reg == rcd_pkg::REQ_INS_L) && (mode_reg == rcd_pkg::MODE_INPUT_RESTRICTED))
        || ((code_reg == rcd_pkg::REQ_DEL_R) && (mode_reg == rcd_pkg::MODE_OUTPUT_RESTRICTED));

    always_comb
    begin
        imm_status = rcd_pkg::ST_OK;
        kind       = rcd_pkg::KIND_IMM;
        priority if (rejected)
        begin
            imm_status = rcd_pkg::ST_REJECTED;
        end
        else if (is_insert)
        begin
            imm_status = full ? rcd_pkg::ST_OVERFLOW : rcd_pkg::ST_OK;
        end
        else if (is_delete)
        begin
            if (empty_reg)
                imm_status = rcd_pkg::ST_UNDERFLOW;
            else
                kind = rcd_pkg::KIND_DEL;
        end
        else
        begin
            if (empty_reg)
                imm_status = rcd_pkg::ST_EMPTY;
            else
                kind = rcd_pkg::KIND_DISP;
        end
    end

    assign disp_fin = (pos_reg == tail_reg) || (cnt_reg == rcd_pkg::idx_t'(rcd_pkg::DEPTH - 1));
    assign out_free = !out_valid_reg || res_ready;
    assign sts      = {kind, out_free, disp_fin};

    // index, empty flag and store write updates
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        if (cmd.load_imm && is_insert && !rejected && !full)
        begin
            ram_we = 1'b1;
            priority if (empty_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                ram_waddr  = '0;
            end
            else if (code_reg == rcd_pkg::REQ_INS_R)
            begin
                tail_next = rcd_pkg::next_idx(tail_reg);
                ram_waddr = rcd_pkg::next_idx(tail_reg);
            end
            else
            begin
                head_next = rcd_pkg::prev_idx(head_reg);
                ram_waddr = rcd_pkg::prev_idx(head_reg);
            end
        end
        else if (cmd.start_del)
        begin
            priority if (head_reg == tail_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
            end
            else if (code_reg == rcd_pkg::REQ_DEL_L)
            begin
                head_next = rcd_pkg::next_idx(head_reg);
            end
            else
            begin
                tail_next = rcd_pkg::prev_idx(tail_reg);
            end
        end
    end

    // read port: delete end, display start, or next display position
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = rcd_pkg::next_idx(pos_reg);
        priority if (cmd.start_del)
        begin
            ram_re    = 1'b1;
            ram_raddr = (code_reg == rcd_pkg::REQ_DEL_L) ? head_reg : tail_reg;
        end
        else if (cmd.start_disp)
        begin
            ram_re    = 1'b1;
            ram_raddr = head_reg;
        end
        else if (cmd.disp_step && !disp_fin)
        begin
            ram_re = 1'b1;
        end
    end

    rcd_ram #(
        .WIDTH (rcd_pkg::WORD_W),
        .DEPTH (rcd_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ($unsigned(value_reg)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_imm || cmd.load_del || cmd.disp_step)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rcd_pkg::MODE_INPUT_RESTRICTED;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
                mode_reg <= cfg_data;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            code_reg  <= req_type;
            value_reg <= value;
        end
        if (cmd.start_disp)
        begin
            pos_reg <= head_reg;
            cnt_reg <= '0;
        end
        else if (cmd.disp_step && !disp_fin)
        begin
            pos_reg <= rcd_pkg::next_idx(pos_reg);
            cnt_reg <= cnt_reg + rcd_pkg::idx_t'(1);
        end
        priority if (cmd.load_imm)
        begin
            status_reg <= imm_status;
            word_reg   <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.load_del || cmd.disp_step)
        begin
            status_reg <= rcd_pkg::ST_OK;
            word_reg   <= $signed(ram_rdata);
            last_reg   <= cmd.load_del ? 1'b1 : disp_fin;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_status = status_reg;
    assign res_word   = word_reg;
    assign res_last   = last_reg;

endmodule

### hdl/restricted_circular_deque.sv
// restricted_circular_deque: top level joining controller and datapath to the channels
// depends on rcd_pkg, rcd_if, rcd_ctrl, rcd_datapath
//
// usage
//   req: one request per transfer (req_type, value); ready is high only while idle
//   res: results (status, word_out, last); last marks the final result of a request
//   cfg: writes the restriction mode bit; always ready, write only while idle
// request sequence
//   insert, reject, overflow, underflow, empty display: request taken in idle, result
//   registered in the exec state once the output register is free, then back to idle
//   delete: the exec state reads the store, the del state registers the word
//   display: the exec state reads the head word, then the disp state registers one word per
//   cycle while res.ready is high; the store's single read port paces the walk
// reset
//   deque empty, indices zero, input-restricted mode; store contents undefined
// stall
//   a result waits in the output register while res.ready is low; the walk
//   and the next request's execution hold until it is taken

module restricted_circular_deque (
    input  logic      clk,
    input  logic      rst_n,
    rcd_req_if.sink   req,
    rcd_res_if.source res,
    rcd_cfg_if.sink   cfg
);

    rcd_pkg::ctrl_cmd_t  cmd;
    rcd_pkg::dp_status_t sts;
    logic                req_fire;
    logic                cfg_fire;

    assign req.ready = cmd.req_ready;
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && cmd.req_ready;
    assign cfg_fire  = cfg.valid;

    rcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .sts      (sts),
        .cmd      (cmd)
    );

    rcd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_fire   (req_fire),
        .req_type   (req.req_type),
        .value      (req.value),
        .cfg_fire   (cfg_fire),
        .cfg_data   (cfg.data),
        .cmd        (cmd),
        .sts        (sts),
        .res_ready  (res.ready),
        .res_valid  (res.valid),
        .res_status (res.status),
        .res_word   (res.word_out),
        .res_last   (res.last)
    );

endmodule

### hdl/rcd_checker.sv
// rcd_checker: port-level assertions for restricted_circular_deque, bound to the top level
// depends on rcd_pkg

module rcd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [rcd_pkg::ST_W-1:0]   res_status,
    input logic [rcd_pkg::WORD_W-1:0] res_word,
    input logic                   res_last
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    // only a display walk gives results that are not last, and those are ok
    a_mid_walk_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> res_status == rcd_pkg::ST_OK)
        else $error("non-final result with error status");

    // error and empty results carry no word
    a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != rcd_pkg::ST_OK |-> res_word == '0)
        else $error("error result with nonzero word");

endmodule

bind restricted_circular_deque rcd_checker u_rcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_status (res.status),
    .res_word   (res.word_out),
    .res_last   (res.last)
);

### tb/restricted_circular_deque_checker.sv
// restricted_circular_deque_checker: watches the request, result and mode channels,
// keeps its own copy of the deque and compares every result in order
// depends on rcd_pkg and the channel interfaces in rcd_if

module restricted_circular_deque_checker (
    input  logic  clk,
    input  logic  rst_n,
    rcd_req_if    req,
    rcd_res_if    res,
    rcd_cfg_if    cfg,
    output int    fails,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        rcd_pkg::status_t status;
        rcd_pkg::word_t   word;
        logic             last;
    } deque_result_t;

    deque_result_t  awaited_results[$];
    rcd_pkg::word_t mirror_store[rcd_pkg::DEPTH];
    rcd_pkg::idx_t  left_idx;
    rcd_pkg::idx_t  right_idx;
    logic           mirror_empty;
    logic           mirror_mode;
    int             fail_count;

    function automatic rcd_pkg::idx_t step_fwd(rcd_pkg::idx_t i);
        return rcd_pkg::idx_t'((int'(i) + 1) % rcd_pkg::DEPTH);
    endfunction

    function automatic rcd_pkg::idx_t step_back(rcd_pkg::idx_t i);
        return rcd_pkg::idx_t'((int'(i) + rcd_pkg::DEPTH - 1) % rcd_pkg::DEPTH);
    endfunction

    function automatic deque_result_t mk_result(rcd_pkg::status_t s, rcd_pkg::word_t w,
                                                logic l);
        deque_result_t r;
        r.status = s;
        r.word   = w;
        r.last   = l;
        return r;
    endfunction

    task automatic predict_deque_op(input rcd_pkg::req_code_t op, input rcd_pkg::word_t v);
        logic           mirror_full;
        logic           fin;
        rcd_pkg::idx_t  pos;
        int             n;
        rcd_pkg::word_t taken;
        mirror_full = !mirror_empty && (step_fwd(right_idx) == left_idx);
        // mode check comes ahead of full and empty checks
        if (op > rcd_pkg::REQ_DISPLAY ||
            (op == rcd_pkg::REQ_INS_L && mirror_mode == rcd_pkg::MODE_INPUT_RESTRICTED) ||
            (op == rcd_pkg::REQ_DEL_R && mirror_mode == rcd_pkg::MODE_OUTPUT_RESTRICTED))
        begin
            awaited_results.push_back(mk_result(rcd_pkg::ST_REJECTED, '0, 1'b1));
        end
        else if (op == rcd_pkg::REQ_INS_R || op == rcd_pkg::REQ_INS_L)
        begin
            if (mirror_full)
            begin
                awaited_results.push_back(mk_result(rcd_pkg::ST_OVERFLOW, '0, 1'b1));
            end
            else
            begin
                if (mirror_empty)
                begin
                    left_idx     = '0;
                    right_idx    = '0;
                    mirror_empty = 1'b0;
                    mirror_store[0] = v;
                end
                else if (op == rcd_pkg::REQ_INS_R)
                begin
                    right_idx = step_fwd(right_idx);
                    mirror_store[right_idx] = v;
                end
                else
                begin
                    left_idx = step_back(left_idx);
                    mirror_store[left_idx] = v;
                end
                awaited_results.push_back(mk_result(rcd_pkg::ST_OK, '0, 1'b1));
            end
        end
        else if (op == rcd_pkg::REQ_DEL_L || op == rcd_pkg::REQ_DEL_R)
        begin
            if (mirror_empty)
            begin
                awaited_results.push_back(mk_result(rcd_pkg::ST_UNDERFLOW, '0, 1'b1));
            end
            else
            begin
                taken = (op == rcd_pkg::REQ_DEL_L) ? mirror_store[left_idx]
                                                   : mirror_store[right_idx];
                if (left_idx == right_idx)
                begin
                    mirror_empty = 1'b1;
                    left_idx     = '0;
                    right_idx    = '0;
                end
                else if (op == rcd_pkg::REQ_DEL_L)
                begin
                    left_idx = step_fwd(left_idx);
                end
                else
                begin
                    right_idx = step_back(right_idx);
                end
                awaited_results.push_back(mk_result(rcd_pkg::ST_OK, taken, 1'b1));
            end
        end
        else if (mirror_empty)
        begin
            awaited_results.push_back(mk_result(rcd_pkg::ST_EMPTY, '0, 1'b1));
        end
        else
        begin
            pos = left_idx;
            n   = 0;
            fin = 1'b0;
            while (!fin)
            begin
                fin = (pos == right_idx) || (n + 1 >= rcd_pkg::DEPTH);
                awaited_results.push_back(mk_result(rcd_pkg::ST_OK, mirror_store[pos], fin));
                n++;
                pos = step_fwd(pos);
            end
        end
    endtask

    task automatic compare_result();
        deque_result_t want;
        if (awaited_results.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected result: expected none, got status %0d word %0d last %0b",
                     $time, res.status, res.word_out, res.last);
        end
        else
        begin
            want = awaited_results.pop_front();
            if (want.status !== res.status || want.word !== res.word_out ||
                want.last !== res.last)
            begin
                fail_count++;
                $display("%0t: result mismatch: expected status %0d word %0d last %0b, ",
                         $time, want.status, want.word, want.last,
                         "got status %0d word %0d last %0b",
                         res.status, res.word_out, res.last);
            end
        end
    endtask

    // channel values are sampled before the edge updates land, outputs go out as nba
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            left_idx     = '0;
            right_idx    = '0;
            mirror_empty = 1'b1;
            mirror_mode  = rcd_pkg::MODE_INPUT_RESTRICTED;
            fail_count   = 0;
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
                compare_result();
            if (cfg.valid && cfg.ready)
                mirror_mode = cfg.data;
            if (req.valid && req.ready)
                predict_deque_op(req.req_type, req.value);
            fails   <= fail_count;
            pending <= awaited_results.size();
        end
    end

endmodule

### tb/restricted_circular_deque_tb.sv
// restricted_circular_deque_tb: clock, reset, request and mode stimulus for the deque,
// random stalls on the result side, and the final verdict
// depends on rcd_pkg, rcd_if, the deque rtl and restricted_circular_deque_checker

module restricted_circular_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    logic mode_now;
    int   fails;
    int   pending;

    rcd_req_if req_ch ();
    rcd_res_if res_ch ();
    rcd_cfg_if cfg_ch ();

    restricted_circular_deque dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    restricted_circular_deque_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .cfg     (cfg_ch),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side stalls in short bursts
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && rst_n && $urandom_range(0, 9) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic issue(input rcd_pkg::req_code_t op, input rcd_pkg::word_t v);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.value    <= v;
        do @(posedge clk); while (!req_ch.ready);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // hold off until every outstanding result is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        mode_now = m;
    endtask

    function automatic rcd_pkg::word_t rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return rcd_pkg::word_t'(32'h7fff_ffff);
        if (r == 1)
            return rcd_pkg::word_t'(32'h8000_0000);
        return rcd_pkg::word_t'($urandom);
    endfunction

    // ins_pct steers the deque toward full or toward empty
    function automatic rcd_pkg::req_code_t pick_op(int ins_pct);
        int   r;
        logic favored;
        r       = $urandom_range(0, 99);
        favored = ($urandom_range(0, 4) != 0);
        if (r < 3)
            return rcd_pkg::req_code_t'($urandom_range(rcd_pkg::REQ_DISPLAY + 1,
                                                       (1 << rcd_pkg::REQ_W) - 1));
        if (r < 12)
            return rcd_pkg::REQ_DISPLAY;
        if (r < 12 + ins_pct)
        begin
            if (mode_now == rcd_pkg::MODE_INPUT_RESTRICTED)
                return favored ? rcd_pkg::REQ_INS_R : rcd_pkg::REQ_INS_L;
            return $urandom_range(0, 1) ? rcd_pkg::REQ_INS_R : rcd_pkg::REQ_INS_L;
        end
        if (mode_now == rcd_pkg::MODE_OUTPUT_RESTRICTED)
            return favored ? rcd_pkg::REQ_DEL_L : rcd_pkg::REQ_DEL_R;
        return $urandom_range(0, 1) ? rcd_pkg::REQ_DEL_L : rcd_pkg::REQ_DEL_R;
    endfunction

    initial
    begin
        int   fill_pct[6];
        logic phase_mode[6];
        fill_pct   = '{70, 15, 45, 75, 10, 45};
        phase_mode = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        calm     = 1'b0;
        mode_now = rcd_pkg::MODE_INPUT_RESTRICTED;
        rst_n    = 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= rcd_pkg::REQ_INS_R;
        req_ch.value    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= rcd_pkg::MODE_INPUT_RESTRICTED;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque, mode rejects and unknown codes, then right inserts, a display and deletes
        issue(rcd_pkg::REQ_DISPLAY, rcd_pkg::word_t'(32'h1234_5678));
        issue(rcd_pkg::REQ_DEL_L, '0);
        issue(rcd_pkg::REQ_DEL_R, '0);
        issue(rcd_pkg::REQ_INS_L, rcd_pkg::word_t'(32'h0bad_cafe));
        for (int k = rcd_pkg::REQ_DISPLAY + 1; k < (1 << rcd_pkg::REQ_W); k++)
            issue(rcd_pkg::req_code_t'(k), rcd_pkg::word_t'(32'hffff_ffff));
        issue(rcd_pkg::REQ_INS_R, rcd_pkg::word_t'(32'h7fff_ffff));
        issue(rcd_pkg::REQ_INS_R, rcd_pkg::word_t'(32'h8000_0000));
        issue(rcd_pkg::REQ_INS_R, '0);
        issue(rcd_pkg::REQ_INS_R, rcd_pkg::word_t'(32'hffff_ffff));
        issue(rcd_pkg::REQ_DISPLAY, '0);
        issue(rcd_pkg::REQ_DEL_R, '0);
        issue(rcd_pkg::REQ_DEL_L, '0);
        issue(rcd_pkg::REQ_DEL_L, '0);
        issue(rcd_pkg::REQ_DEL_L, '0);

        // output-restricted: a left insert into a one-word deque wraps the head
        write_mode(rcd_pkg::MODE_OUTPUT_RESTRICTED);
        issue(rcd_pkg::REQ_INS_L, rcd_pkg::word_t'(32'h5555_5555));
        issue(rcd_pkg::REQ_DEL_R, '0);
        issue(rcd_pkg::REQ_INS_L, rcd_pkg::word_t'(32'haaaa_aaaa));
        issue(rcd_pkg::REQ_INS_R, rcd_pkg::word_t'(32'h0000_0001));
        issue(rcd_pkg::REQ_DISPLAY, '0);
        issue(rcd_pkg::REQ_DEL_L, '0);
        issue(rcd_pkg::REQ_DEL_L, '0);
        issue(rcd_pkg::REQ_DEL_L, '0);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_mode(phase_mode[ph]);
            if (ph == 5)
                calm = 1'b1;
            for (int i = 0; i < 26; i++)
                issue(pick_op(fill_pct[ph]), rand_word());
        end

        drain();
        repeat (12) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
